### src/lattice_offset_fit_score_macros.svh
// Assertion macros for the lattice offset fit scorer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef LATTICE_OFFSET_FIT_SCORE_MACROS_SVH
`define LATTICE_OFFSET_FIT_SCORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LOFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lofs assertion failed");

// Next-cycle implication, disabled during reset.
`define LOFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lofs assertion failed");

`endif

### src/lofs_pkg.sv
// Shared types and constants of the lattice offset fit scorer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lofs_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_SPACING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT      = 2'd2;

	// Field widths
	localparam int START_W   = 18;
	localparam int SPACING_W = 16;
	localparam int COUNT_W   = 6;
	localparam int POS_W     = 16;
	localparam int RMS_W     = 16;

	// Distance center - start, signed; error of a center, signed
	localparam int DIST_W = 19;
	localparam int ERR_W  = 18;

	// Shared divider: numerator, denominator, iteration counter
	localparam int DIV_NUM_W  = 36;
	localparam int DIV_DEN_W  = 17;
	localparam int DIV_CNT_W  = 6;
	localparam logic [DIV_CNT_W-1:0] CENTER_DIV_ITERS = DIV_CNT_W'(DIST_W);
	localparam logic [DIV_CNT_W-1:0] MEAN_DIV_ITERS   = DIV_CNT_W'(DIV_NUM_W);

	// Sum of squares and square root
	localparam int SUM_W      = 36;
	localparam int SQRT_IN_W  = 32;
	localparam int SQRT_OUT_W = 16;
	localparam int SQRT_REM_W = 18;
	localparam int SQRT_CNT_W = 4;

	// Sequencer states
	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_PREP  = 11'b000_0000_0010,
		S_DIV   = 11'b000_0000_0100,
		S_CMP   = 11'b000_0000_1000,
		S_CHECK = 11'b000_0001_0000,
		S_WALK  = 11'b000_0010_0000,
		S_DRAIN = 11'b000_0100_0000,
		S_MEAN  = 11'b000_1000_0000,
		S_MDIV  = 11'b001_0000_0000,
		S_SQRT  = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} lofs_state_t;

	// Divider request
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} lofs_div_ctl_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} lofs_div_sts_t;

	// Magnitude of a signed error
	function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] v);
		return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
	endfunction

endpackage

### src/lattice_offset_fit_score.sv
// Lattice offset fit scorer, top level.
// Depends on lofs_pkg, lofs_div, lofs_sqrt and lattice_offset_fit_score_macros.svh.
`timescale 1ns / 1ps
`include "lattice_offset_fit_score_macros.svh"

// Each center word is mapped to its nearest lattice index by a bit-serial
// divider (one quotient bit per cycle). A center accepted in the idle state
// then passes the setup state, the divider start, the divide steps, the
// divider's done, at which the error store is also read, the keep-closest
// compare and the check state, and only then can the next center be
// accepted. A center whose index falls outside the lattice skips the
// compare; with zero spacing or zero lines it goes from idle straight to the
// check state. A center marked last adds the final pass: a walk of the
// error store, a drain of the walk pipeline, the mean setup, the 36-step
// mean divide with its start and done, the 16-step square root likewise and
// the load of the result; divide and root are skipped when no index was
// hit. The result sits in an output register; the next set can start while
// it waits, and the load of a further result waits until that register is
// free. There is no clearing pass after reset.
module lattice_offset_fit_score #(
	parameter int MAX_LINES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lofs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lofs_pkg::START_W-1:0]          cfg_data,
	// center input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lofs_pkg::POS_W-1:0]            center_position,
	input  logic                                  last_center,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  fit_found,
	output logic [lofs_pkg::COUNT_W-1:0]          inlier_count,
	output logic [lofs_pkg::COUNT_W-1:0]          span_length,
	output logic [lofs_pkg::RMS_W-1:0]            rms_error
);
	import lofs_pkg::*;

	localparam int IDX_W = $clog2(MAX_LINES);
	localparam int N_W   = $clog2(MAX_LINES + 1);
	localparam int CMP_W = (N_W > COUNT_W) ? N_W : COUNT_W;

	// Config registers
	logic signed [START_W-1:0] start_q;
	logic [SPACING_W-1:0]      spacing_q;
	logic [COUNT_W-1:0]        line_count_q;
	logic [N_W-1:0]            n_act;

	// Sequencer and walk control
	lofs_state_t               state_q;
	logic [N_W-1:0]            idx_q;
	logic                      v_s1;
	logic                      v_s2;
	logic [MAX_LINES-1:0]      hit_q;

	// Center datapath
	logic signed [DIST_W-1:0]  d_q;
	logic                      last_q;
	logic [DIST_W-1:0]         dist_mag;
	logic [DIST_W-1:0]         div_num_c;
	logic [DIST_W-1:0]         quot_c;
	logic                      drop_c;
	logic signed [ERR_W-1:0]   diff_c;
	logic signed [ERR_W-1:0]   em_c;
	logic [IDX_W-1:0]          k_q;
	logic signed [ERR_W-1:0]   e_q;
	logic                      upd_c;

	// Error store
	logic signed [ERR_W-1:0]   err_mem [MAX_LINES];
	logic signed [ERR_W-1:0]   rd_q;
	logic [IDX_W-1:0]          rd_addr;

	// Final pass datapath
	logic                      hit_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [2*ERR_W-1:0]        sq_s2;
	logic [SUM_W-1:0]          sum_q;
	logic [N_W-1:0]            cnt_q;
	logic [IDX_W-1:0]          lo_q;
	logic [IDX_W-1:0]          hi_q;
	logic [RMS_W-1:0]          rms_q;

	// Shared divider and square root
	lofs_div_ctl_t             div_ctl_q;
	lofs_div_sts_t             div_sts;
	logic [DIV_NUM_W-1:0]      div_num_q;
	logic [DIV_DEN_W-1:0]      div_den_q;
	logic [DIV_NUM_W-1:0]      div_quot;
	logic [DIV_DEN_W-1:0]      div_rem;
	logic                      sqrt_start_q;
	logic                      sqrt_done;
	logic [SQRT_OUT_W-1:0]     sqrt_root;

	// Output register
	logic                      out_valid_q;
	logic                      out_free;
	logic                      fit_q;
	logic [COUNT_W-1:0]        inlier_q;
	logic [COUNT_W-1:0]        span_q;
	logic [RMS_W-1:0]          rms_out_q;

	// Active line count, saturated to MAX_LINES
	assign n_act = (CMP_W'(line_count_q) > CMP_W'(MAX_LINES)) ?
		N_W'(MAX_LINES) : N_W'(line_count_q);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Divide operands for index: (2|d| + s) / (2s)
	assign dist_mag  = d_q[DIST_W-1] ? DIST_W'(-d_q) : DIST_W'(d_q);
	assign div_num_c = {dist_mag[DIST_W-2:0], 1'b0} + DIST_W'(spacing_q);

	// Quotient check and error from remainder: e = sign(d) * (r - s) / 2
	assign quot_c = div_quot[DIST_W-1:0];
	assign drop_c = (d_q[DIST_W-1] && (quot_c != '0)) || (quot_c >= DIST_W'(n_act));
	assign diff_c = $signed({1'b0, div_rem}) - $signed({2'b00, spacing_q});
	assign em_c   = diff_c >>> 1;

	// Keep the closest center; first one wins a tie
	assign upd_c = !hit_q[k_q] || (err_mag(e_q) < err_mag(rd_q));

	// Single read port shared by compare and final walk
	assign rd_addr = (state_q == S_WALK) ? idx_q[IDX_W-1:0] : quot_c[IDX_W-1:0];

	lofs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.sts    (div_sts),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	lofs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (div_quot[SQRT_IN_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			spacing_q    <= SPACING_W'(1200);
			line_count_q <= COUNT_W'(19);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LATTICE_START:   start_q      <= cfg_data;
				CFG_LATTICE_SPACING: spacing_q    <= cfg_data[SPACING_W-1:0];
				CFG_LINE_COUNT:      line_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			hit_q        <= '0;
			div_ctl_q    <= '0;
			sqrt_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_ctl_q.start <= 1'b0;
			sqrt_start_q    <= 1'b0;
			v_s1            <= 1'b0;
			v_s2            <= v_s1 && hit_s1;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= ((spacing_q == '0) || (n_act == '0)) ? S_CHECK : S_PREP;
					end
				end
				S_PREP: begin
					div_ctl_q.start <= 1'b1;
					div_ctl_q.iters <= CENTER_DIV_ITERS;
					state_q         <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= drop_c ? S_CHECK : S_CMP;
					end
				end
				S_CMP: begin
					if (upd_c) begin
						hit_q[k_q] <= 1'b1;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					idx_q <= '0;
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (n_act == '0) begin
						state_q <= S_DRAIN;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					v_s1  <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (idx_q + N_W'(1) == n_act) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						div_ctl_q.start <= 1'b1;
						div_ctl_q.iters <= MEAN_DIV_ITERS;
						state_q         <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (div_sts.done) begin
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Error store: one write, one registered read
	always_ff @(posedge clk) begin
		if ((state_q == S_CMP) && upd_c) begin
			err_mem[k_q] <= e_q;
		end
		rd_q <= err_mem[rd_addr];
	end

	// Datapath
	always_ff @(posedge clk) begin
		// accept a center word
		if ((state_q == S_IDLE) && in_valid) begin
			d_q    <= $signed({3'b000, center_position}) - $signed({start_q[START_W-1], start_q});
			last_q <= last_center;
		end
		// divider operands
		if (state_q == S_PREP) begin
			div_num_q <= {div_num_c, (DIV_NUM_W - DIST_W)'(0)};
			div_den_q <= {spacing_q, 1'b0};
		end else if (state_q == S_MEAN) begin
			div_num_q <= sum_q;
			div_den_q <= DIV_DEN_W'(cnt_q);
		end
		// index and signed error of this center
		if ((state_q == S_DIV) && div_sts.done) begin
			k_q <= quot_c[IDX_W-1:0];
			e_q <= d_q[DIST_W-1] ? -em_c : em_c;
		end
		// final pass: clear accumulators
		if (state_q == S_CHECK) begin
			cnt_q <= '0;
			sum_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
		end
		// walk stage 1: hit flag and index of the entry being read
		hit_s1 <= (state_q == S_WALK) && hit_q[idx_q[IDX_W-1:0]];
		idx_s1 <= idx_q[IDX_W-1:0];
		// stage 2 input: count, span, square
		if (v_s1 && hit_s1) begin
			if (cnt_q == '0) begin
				lo_q <= idx_s1;
			end
			hi_q  <= idx_s1;
			cnt_q <= cnt_q + 1'b1;
		end
		sq_s2 <= err_mag(rd_q) * err_mag(rd_q);
		// stage 2: accumulate
		if (v_s2) begin
			sum_q <= sum_q + SUM_W'(sq_s2);
		end
		// root of the mean square; mean stays below 2^30 so no saturation occurs
		if (state_q == S_MEAN) begin
			rms_q <= '0;
		end else if ((state_q == S_SQRT) && sqrt_done) begin
			rms_q <= RMS_W'(sqrt_root);
		end
		// result word
		if ((state_q == S_OUT) && out_free) begin
			fit_q     <= (cnt_q != '0);
			inlier_q  <= COUNT_W'(cnt_q);
			span_q    <= (cnt_q != '0) ?
				COUNT_W'(N_W'(hi_q) - N_W'(lo_q) + N_W'(1)) : '0;
			rms_out_q <= rms_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign fit_found    = fit_q;
	assign inlier_count = inlier_q;
	assign span_length  = span_q;
	assign rms_error    = rms_out_q;

	// A new result only ever comes from the output state
	`LOFS_ASSERT_NOW(a_result_from_out, $rose(out_valid_q), $past(state_q == S_OUT))
	// Hit flags are all clear once a result has been loaded
	`LOFS_ASSERT_NEXT(a_hits_cleared, (state_q == S_OUT) && out_free, hit_q == '0)
	// A reported fit carries a nonzero count and span
	`LOFS_ASSERT_NOW(a_fit_counts, out_valid_q && fit_q, (inlier_q != '0) && (span_q != '0))

endmodule

### src/lofs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lofs_pkg. Numerator is left aligned; quotient lands in the low bits.
`timescale 1ns / 1ps

module lofs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lofs_pkg::lofs_div_ctl_t           ctl,
	input  logic [lofs_pkg::DIV_NUM_W-1:0]    num,
	input  logic [lofs_pkg::DIV_DEN_W-1:0]    den,
	output lofs_pkg::lofs_div_sts_t           sts,
	output logic [lofs_pkg::DIV_NUM_W-1:0]    quot,
	output logic [lofs_pkg::DIV_DEN_W-1:0]    rem
);
	import lofs_pkg::*;

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 fits;

	// One restoring step
	assign rem_sh = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift numerator out, quotient bits in
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = num_q;
	assign rem      = rem_q[DIV_DEN_W-1:0];

endmodule

### src/lofs_sqrt.sv
// Digit-serial integer square root, one root bit per cycle (floor).
// Depends on lofs_pkg.
`timescale 1ns / 1ps

module lofs_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lofs_pkg::SQRT_IN_W-1:0]    radicand,
	output logic                              done,
	output logic [lofs_pkg::SQRT_OUT_W-1:0]   root
);
	import lofs_pkg::*;

	logic [SQRT_IN_W-1:0]   x_q;
	logic [SQRT_REM_W-1:0]  rem_q;
	logic [SQRT_OUT_W-1:0]  root_q;
	logic [SQRT_CNT_W-1:0]  cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SQRT_REM_W+1:0]  rem_sh;
	logic [SQRT_REM_W+1:0]  trial;
	logic                   fits;

	// Bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q, x_q[SQRT_IN_W-1 -: 2]};
	assign trial  = (SQRT_REM_W + 2)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= fits ? SQRT_REM_W'(rem_sh - trial) : SQRT_REM_W'(rem_sh);
			root_q <= {root_q[SQRT_OUT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the lattice offset fit scorer.
// Depends on lofs_pkg and lattice_offset_fit_score; drives centers, checks scores.
`timescale 1ns / 1ps

module tb;
	import lofs_pkg::*;

	localparam int LINES_MAX     = 32;
	localparam int TOTAL_CENTERS = 850;
	localparam int SETTLE_CYCLES = 150;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct {
		logic                fit;
		logic [COUNT_W-1:0]  inliers;
		logic [COUNT_W-1:0]  span;
		logic [RMS_W-1:0]    rms;
	} fit_result_t;

	typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [START_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [POS_W-1:0]     center_position;
	logic                 last_center;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 fit_found;
	logic [COUNT_W-1:0]   inlier_count;
	logic [COUNT_W-1:0]   span_length;
	logic [RMS_W-1:0]     rms_error;

	// Lattice registers as the scorer should see them
	logic signed [START_W-1:0] lat_start;
	logic [SPACING_W-1:0]      lat_spacing;
	logic [COUNT_W-1:0]        lat_lines;

	// Closest error per lattice index and its hit flag
	logic signed [ERR_W-1:0] kept_err [LINES_MAX];
	bit                      kept_hit [LINES_MAX];

	fit_result_t expected_fits [$];

	int          fail_count = 0;
	int          centers_sent = 0;
	int          cycle_count = 0;
	bit          gaps_enabled = 1'b1;
	int          burst_left = 0;
	int          out_hold_cycles = 0;
	rx_pattern_t rx_pattern = RX_FLOW;
	int          rx_pattern_left = 0;

	lattice_offset_fit_score #(
		.MAX_LINES(LINES_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.center_position(center_position),
		.last_center(last_center),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fit_found(fit_found),
		.inlier_count(inlier_count),
		.span_length(span_length),
		.rms_error(rms_error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Scoring predictor
	// ---------------------------------------------------------------

	// Line count saturates at the store depth
	function automatic longint active_lines();
		return (lat_lines > LINES_MAX) ? longint'(LINES_MAX) : longint'(lat_lines);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r = 0;
		longint unsigned t;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// Nearest index, half away from zero; keep the strictly closer error
	function automatic void map_center(input logic [POS_W-1:0] pos);
		longint s, n, d, ad, k, e, ae, ab;
		s = longint'(lat_spacing);
		n = active_lines();
		if (s == 0 || n == 0)
			return;
		d = longint'(pos) - longint'(lat_start);
		ad = (d < 0) ? -d : d;
		k = (2 * ad + s) / (2 * s);
		if (d < 0)
			k = -k;
		if (k < 0 || k >= n)
			return;
		e = d - k * s;
		ae = (e < 0) ? -e : e;
		ab = longint'(kept_err[k]);
		if (ab < 0)
			ab = -ab;
		if (!kept_hit[k] || ae < ab) begin
			kept_err[k] = ERR_W'(e);
			kept_hit[k] = 1'b1;
		end
	endfunction

	// Final pass over the store, then clear the hit flags
	function automatic fit_result_t score_set();
		fit_result_t     r;
		longint unsigned sumsq = 0;
		longint unsigned root;
		longint          e;
		int              hits = 0;
		int              lo = 0;
		int              hi = 0;
		int              n;
		n = int'(active_lines());
		for (int k = 0; k < n; k++) begin
			if (kept_hit[k]) begin
				if (hits == 0)
					lo = k;
				hi = k;
				hits++;
				e = longint'(kept_err[k]);
				sumsq += longint'(e * e);
			end
		end
		r.fit = (hits != 0);
		r.inliers = COUNT_W'(hits);
		r.span = (hits != 0) ? COUNT_W'(hi - lo + 1) : '0;
		r.rms = '0;
		if (hits != 0) begin
			root = floor_sqrt(sumsq / hits);
			r.rms = (root > 65535) ? 16'hFFFF : RMS_W'(root);
		end
		for (int k = 0; k < LINES_MAX; k++)
			kept_hit[k] = 1'b0;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result check and receiver stall
	// ---------------------------------------------------------------

	always @(posedge clk) begin : result_check
		fit_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fits.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				want = expected_fits.pop_front();
				if (fit_found !== want.fit) begin
					$error("fit_found: expected %0d, actual %0d", want.fit, fit_found);
					fail_count++;
				end
				if (inlier_count !== want.inliers) begin
					$error("inlier_count: expected %0d, actual %0d", want.inliers,
						inlier_count);
					fail_count++;
				end
				if (span_length !== want.span) begin
					$error("span_length: expected %0d, actual %0d", want.span, span_length);
					fail_count++;
				end
				if (rms_error !== want.rms) begin
					$error("rms_error: expected %0d, actual %0d", want.rms, rms_error);
					fail_count++;
				end
			end
		end
	end

	// Receiver: a long hold-off when asked, else a changing stall pattern
	always @(posedge clk) begin
		if (out_hold_cycles > 0) begin
			out_stall <= 1'b1;
			out_hold_cycles--;
		end else begin
			if (rx_pattern_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				rx_pattern_left = $urandom_range(10, 200);
			end
			rx_pattern_left--;
			case (rx_pattern)
				RX_FLOW: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= rx_pattern_left[2];
			endcase
		end
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Drop valid, let every score arrive, then let the block go quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_fits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register word; valid stays high for the caller to reuse or drop
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [START_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_LATTICE_START: lat_start = data;
			CFG_LATTICE_SPACING: lat_spacing = data[SPACING_W-1:0];
			CFG_LINE_COUNT: lat_lines = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Unused upper data bits carry noise
	task automatic program_lattice(input logic signed [START_W-1:0] st,
		input logic [SPACING_W-1:0] sp, input logic [COUNT_W-1:0] nl);
		logic [START_W-1:0] word;
		wait_idle();
		cfg_put(CFG_LATTICE_START, st);
		word = START_W'($urandom);
		word[SPACING_W-1:0] = sp;
		cfg_put(CFG_LATTICE_SPACING, word);
		word = START_W'($urandom);
		word[COUNT_W-1:0] = nl;
		cfg_put(CFG_LINE_COUNT, word);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_line_count(input logic [COUNT_W-1:0] nl);
		wait_idle();
		cfg_put(CFG_LINE_COUNT, START_W'(nl));
		cfg_valid <= 1'b0;
	endtask

	// Send one center word; valid stays high after acceptance
	task automatic send_center(input logic [POS_W-1:0] pos, input bit last);
		int gap;
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 24);
				burst_left = $urandom_range(0, 10);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
		in_valid <= 1'b1;
		center_position <= pos;
		last_center <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		map_center(pos);
		if (last)
			expected_fits.insert(expected_fits.size(), score_set());
		centers_sent++;
	endtask

	// Center near a lattice line, often on an exact half, sometimes noise
	function automatic logic [POS_W-1:0] lattice_pick();
		longint s, n, k, half, p;
		s = (lat_spacing == '0) ? 1000 : longint'(lat_spacing);
		n = active_lines();
		if (n == 0)
			n = 4;
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom);
		k = longint'($urandom_range(0, int'(n + 1))) - 1;
		half = s / 2;
		case ($urandom_range(0, 3))
			0: p = 0;
			1: p = half;
			2: p = -half;
			default: p = longint'($urandom_range(0, int'(2 * half + 4))) - half - 2;
		endcase
		p += longint'(lat_start) + k * s;
		if (p < 0 || p > 65535)
			return POS_W'($urandom);
		return POS_W'(p);
	endfunction

	task automatic random_set();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			send_center(lattice_pick(), i == len - 1);
	endtask

	task automatic program_random_lattice();
		logic signed [START_W-1:0] st;
		logic [SPACING_W-1:0]      sp;
		logic [COUNT_W-1:0]        nl;
		sp = SPACING_W'($urandom_range(16, 6000));
		nl = COUNT_W'($urandom_range(1, 32));
		st = START_W'(int'($urandom_range(0, 40000)) - 8000);
		case ($urandom_range(0, 9))
			0: begin
				sp = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				nl = $urandom_range(0, 1) ? 6'd32 : 6'd1;
				case ($urandom_range(0, 2))
					0: st = START_W'(-131072);
					1: st = START_W'(131071);
					default: st = '0;
				endcase
			end
			1: begin
				sp = SPACING_W'($urandom_range(1, 65535));
				st = START_W'($urandom);
			end
			2: begin
				case ($urandom_range(0, 2))
					0: sp = '0;
					1: nl = '0;
					default: nl = COUNT_W'($urandom_range(33, 63));
				endcase
			end
			default: ;
		endcase
		program_lattice(st, sp, nl);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset lattice: on-line, half-way, out of range, closer replacement
	task automatic test_default_lattice();
		send_center(16'd0, 1'b0);
		send_center(16'd600, 1'b0);
		send_center(16'd21600, 1'b0);
		send_center(16'hFFFF, 1'b0);
		send_center(16'd1210, 1'b1);
	endtask

	// Equal error keeps the first center, a strictly closer one replaces it
	task automatic test_tie_keeps_first();
		program_lattice('0, 16'd100, 6'd8);
		send_center(16'd240, 1'b0);
		send_center(16'd160, 1'b0);
		send_center(16'd230, 1'b0);
		send_center(16'd300, 1'b1);
	endtask

	task automatic test_no_hits();
		program_lattice(START_W'(131071), 16'd1200, 6'd19);
		send_center(16'd0, 1'b1);
	endtask

	task automatic test_extreme_registers();
		program_lattice(START_W'(-131072), 16'hFFFF, 6'd32);
		send_center(16'hFFFF, 1'b0);
		send_center(16'd0, 1'b1);
		program_lattice('0, 16'd1, 6'd32);
		send_center(16'd5, 1'b0);
		send_center(16'd32, 1'b0);
		send_center(16'd31, 1'b1);
	endtask

	// Zero spacing, zero lines, line count above the store depth
	task automatic test_degenerate_lattice();
		program_lattice('0, 16'd0, 6'd19);
		send_center(16'd100, 1'b1);
		program_lattice('0, 16'd1200, 6'd0);
		send_center(16'd0, 1'b1);
		program_lattice('0, 16'd16, 6'd63);
		send_center(16'd496, 1'b0);
		send_center(16'd512, 1'b0);
		send_center(16'd0, 1'b1);
	endtask

	// Shrinking N inside a set drops the hit above the new count
	task automatic test_count_change_in_set();
		program_lattice('0, 16'd100, 6'd8);
		send_center(16'd0, 1'b0);
		send_center(16'd700, 1'b0);
		set_line_count(6'd4);
		send_center(16'd300, 1'b1);
	endtask

	// Receiver holds off while short sets keep coming, then the sender waits
	task automatic test_output_hold();
		program_lattice('0, 16'd100, 6'd4);
		gaps_enabled = 1'b0;
		out_hold_cycles = 3000;
		repeat (6) begin
			send_center(16'd100, 1'b0);
			send_center(16'd210, 1'b1);
		end
		wait_idle();
		gaps_enabled = 1'b1;
	endtask

	task automatic test_random_sets();
		while (centers_sent < TOTAL_CENTERS) begin
			program_random_lattice();
			gaps_enabled = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 8)) random_set();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LATTICE_START;
		cfg_data <= '0;
		in_valid <= 1'b0;
		center_position <= '0;
		last_center <= 1'b0;
		lat_start = '0;
		lat_spacing = 16'd1200;
		lat_lines = 6'd19;
		for (int k = 0; k < LINES_MAX; k++) begin
			kept_err[k] = '0;
			kept_hit[k] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_lattice();
		test_tie_keeps_first();
		test_no_hits();
		test_extreme_registers();
		test_degenerate_lattice();
		test_count_change_in_set();
		test_output_hold();
		test_random_sets();
		wait_idle();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
